### hw/rtl/alr_pkg.sv
// ----------------------------------------------------------------------------
// alr_pkg: antialiased line rasterizer shared definitions
// Widths, fixed-point constants and the result record.
// ----------------------------------------------------------------------------
package alr_pkg;

    localparam int TILE_SIZE      = 64;
    localparam int FRAC_BITS      = 4;
    localparam int INTENSITY_BITS = 8;
    localparam int GRAD_FRAC      = 12;
    localparam int ACC_FRAC       = GRAD_FRAC + FRAC_BITS;

    localparam int TILE_W  = $clog2(TILE_SIZE);
    localparam int COORD_W = TILE_W + FRAC_BITS;
    localparam int COL_W   = TILE_W + 1;
    localparam int GAP_W   = FRAC_BITS + 1;
    localparam int QUO_W   = GRAD_FRAC + 1;
    localparam int GRAD_W  = QUO_W + 1;
    localparam int NUM_W   = COORD_W + GRAD_FRAC;
    localparam int ACC_W   = ACC_FRAC + TILE_W + 3;
    localparam int MUL_W   = GRAD_W + GAP_W;
    localparam int CNT_W   = $clog2(QUO_W + 1);

    localparam int IN_TDATA_W  = ((4 * COORD_W + 7) / 8) * 8;
    localparam int OUT_RAW_W   = 2 * TILE_W + 2 * INTENSITY_BITS;
    localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    localparam logic [FRAC_BITS-1:0] FRAC_HALF = FRAC_BITS'(1 << (FRAC_BITS - 1));
    localparam logic [GAP_W-1:0]     GAP_ONE   = GAP_W'(1 << FRAC_BITS);
    localparam logic [COL_W-1:0]     COL_TILE  = COL_W'(TILE_SIZE);
    localparam logic [COL_W-1:0]     COL_EDGE  = COL_W'(TILE_SIZE - 1);

    typedef struct packed {
        logic [TILE_W-1:0]         major;
        logic [TILE_W-1:0]         minor;
        logic [INTENSITY_BITS-1:0] near_i;
        logic [INTENSITY_BITS-1:0] far_i;
        logic                      steep;
        logic                      last;
    } t_res;

endpackage

### hw/rtl/alr_div.sv
// ----------------------------------------------------------------------------
// alr_div: gradient divider
// Restoring radix-2 divider, one quotient bit per cycle. The quotient is
// known to fit QUO_W bits, so the upper numerator bits seed the remainder.
// ----------------------------------------------------------------------------
module alr_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [alr_pkg::NUM_W-1:0]   i_num,
    input  logic [alr_pkg::COORD_W-1:0] i_den,
    output logic                        o_done,
    output logic [alr_pkg::QUO_W-1:0]   o_quo
);
    import alr_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [COORD_W-1:0] r_rem;
    logic [QUO_W-1:0]   r_dvd;
    logic [QUO_W-1:0]   r_quo;
    logic [COORD_W-1:0] r_den;

    logic [COORD_W:0]   trial_src;
    logic [COORD_W:0]   trial;
    logic               take;

    always_comb begin
        trial_src = {r_rem, r_dvd[QUO_W-1]};
        trial     = trial_src - {1'b0, r_den};
        take      = (trial_src >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QUO_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= COORD_W'(i_num[NUM_W-1:QUO_W]);
            r_dvd <= i_num[QUO_W-1:0];
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= take ? trial[COORD_W-1:0] : trial_src[COORD_W-1:0];
            r_dvd <= {r_dvd[QUO_W-2:0], 1'b0};
            r_quo <= {r_quo[QUO_W-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

### hw/rtl/alr_shade.sv
// ----------------------------------------------------------------------------
// alr_shade: column coverage
// Splits the minor position into pixel and fraction, weights both pixels
// of the pair by the column gap and clips the pair against the tile.
// ----------------------------------------------------------------------------
module alr_shade (
    input  logic signed [alr_pkg::ACC_W-1:0] i_acc,
    input  logic [alr_pkg::GAP_W-1:0]        i_gap,
    input  logic [alr_pkg::COL_W-1:0]        i_col,
    input  logic                             i_steep,
    input  logic                             i_last,
    output alr_pkg::t_res                    o_res
);
    import alr_pkg::*;

    localparam int PART_W = ACC_FRAC + 1;
    localparam int PROD_W = PART_W + GAP_W;
    localparam int SH     = ACC_FRAC + FRAC_BITS;
    localparam int SCL_W  = PROD_W + INTENSITY_BITS;

    function automatic logic [INTENSITY_BITS-1:0] cov(input logic [PART_W-1:0] part,
                                                      input logic [GAP_W-1:0]  gap);
        logic [PROD_W-1:0] x;
        logic [SCL_W-1:0]  y;
        x = part * gap;
        y = {x, {INTENSITY_BITS{1'b0}}} - SCL_W'(x) + SCL_W'(1 << (SH - 1));
        return y[SH+INTENSITY_BITS-1:SH];
    endfunction

    logic signed [ACC_W-ACC_FRAC-1:0] pix;
    logic [PART_W-1:0]                fpart;
    logic [PART_W-1:0]                rfpart;
    logic [INTENSITY_BITS-1:0]        near_v;
    logic [INTENSITY_BITS-1:0]        far_v;

    always_comb begin
        pix    = i_acc[ACC_W-1:ACC_FRAC];
        fpart  = {1'b0, i_acc[ACC_FRAC-1:0]};
        rfpart = PART_W'(1 << ACC_FRAC) - fpart;
        near_v = cov(rfpart, i_gap);
        far_v  = cov(fpart, i_gap);

        o_res.major = i_col[TILE_W-1:0];
        o_res.steep = i_steep;
        o_res.last  = i_last;
        priority if (pix < 0) begin
            o_res.minor  = '0;
            o_res.near_i = far_v;
            o_res.far_i  = '0;
        end else if (pix >= (ACC_W-ACC_FRAC)'(TILE_SIZE)) begin
            o_res.minor  = TILE_W'(TILE_SIZE - 1);
            o_res.near_i = '0;
            o_res.far_i  = '0;
        end else begin
            o_res.minor  = pix[TILE_W-1:0];
            o_res.near_i = near_v;
            o_res.far_i  = (pix == (ACC_W-ACC_FRAC)'(TILE_SIZE - 1)) ? '0 : far_v;
        end
    end

endmodule

### hw/rtl/antialiased_line_rasterizer.sv
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer: Wu antialiased line, one tile
//
//   port group   dir  tdata (low bit up)                  side fields
//   s_axis       in   start_x, start_y, end_x, end_y      -
//   m_axis       out  major, minor, near_i, far_i, pad    tuser steep, tlast
//
// One segment: accept, setup and divider start, the divider (13 quotient bits
// and a done strobe), the multiply states S_MULS and S_MULE, then one cycle
// per emitted column (at most 64) while the output register is not stalled.
// Takes a new segment only when the previous one has issued its last word.
// Output register holds a word until m_axis_tready; column loop stalls.
// Reset: synchronous, active low; returns to idle with no word pending.
// ----------------------------------------------------------------------------
module antialiased_line_rasterizer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // start_x, start_y, end_x, end_y
    input  logic [alr_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // major_coord, minor_coord, near_intensity, far_intensity, zero pad
    output logic [alr_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // steep
    output logic                            o_m_axis_tuser,
    output logic                            o_m_axis_tlast
);
    import alr_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SETUP  = 9'b000000010,
        S_DSTART = 9'b000000100,
        S_DIV    = 9'b000001000,
        S_MULS   = 9'b000010000,
        S_MULE   = 9'b000100000,
        S_EMIT_A = 9'b001000000,
        S_EMIT_M = 9'b010000000,
        S_EMIT_B = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [COORD_W-1:0] r_sx, r_sy, r_ex, r_ey;
    logic               r_steep;
    logic [COORD_W-1:0] r_amin, r_bmin, r_dmaj, r_mag;
    logic               r_neg;
    logic [COL_W-1:0]   r_c1, r_c2, r_col;
    logic [GAP_W-1:0]   r_gap1, r_gap2;
    logic signed [GAP_W-1:0]  r_off1, r_off2;
    logic signed [GRAD_W-1:0] r_grad;
    logic signed [ACC_W-1:0]  r_acc, r_acc_end;
    logic               r_ovalid;
    t_res               r_res;

    // setup
    logic signed [COORD_W:0] dx, dy, dmin;
    logic [COORD_W-1:0] adx, ady, pa_maj, pa_min, pb_maj, pb_min;
    logic [COORD_W-1:0] amaj, amin, bmaj, bmin;
    logic               steep;
    logic [COORD_W:0]   sum1, sum2;

    always_comb begin
        dx    = $signed({1'b0, r_ex}) - $signed({1'b0, r_sx});
        dy    = $signed({1'b0, r_ey}) - $signed({1'b0, r_sy});
        adx   = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
        ady   = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
        steep = !(adx > ady);
        pa_maj = steep ? r_sy : r_sx;
        pa_min = steep ? r_sx : r_sy;
        pb_maj = steep ? r_ey : r_ex;
        pb_min = steep ? r_ex : r_ey;
        if (pa_maj > pb_maj) begin
            amaj = pb_maj; amin = pb_min; bmaj = pa_maj; bmin = pa_min;
        end else begin
            amaj = pa_maj; amin = pa_min; bmaj = pb_maj; bmin = pb_min;
        end
        dmin = $signed({1'b0, bmin}) - $signed({1'b0, amin});
        sum1 = {1'b0, amaj} + (COORD_W+1)'(FRAC_HALF);
        sum2 = {1'b0, bmaj} + (COORD_W+1)'(FRAC_HALF);
    end

    // divider
    logic               div_start, div_done;
    logic [QUO_W-1:0]   div_quo;
    logic [NUM_W-1:0]   div_num;

    assign div_start = (r_state == S_DSTART);
    assign div_num   = {r_mag, {GRAD_FRAC{1'b0}}} + NUM_W'(r_dmaj >> 1);

    alr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_dmaj),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // shared multiplier for the two endpoint positions
    logic signed [GAP_W-1:0] mul_off;
    logic signed [MUL_W-1:0] mul_p;
    logic [COORD_W-1:0]      mul_base;
    logic signed [ACC_W-1:0] mul_acc;
    logic signed [ACC_W-1:0] grad_step;

    always_comb begin
        mul_off   = (r_state == S_MULS) ? r_off1 : r_off2;
        mul_base  = (r_state == S_MULS) ? r_amin : r_bmin;
        mul_p     = r_grad * mul_off;
        mul_acc   = $signed(ACC_W'({mul_base, {GRAD_FRAC{1'b0}}})) + ACC_W'(mul_p);
        grad_step = $signed({{(ACC_W-GRAD_W-FRAC_BITS){r_grad[GRAD_W-1]}}, r_grad,
                             {FRAC_BITS{1'b0}}});
    end

    // column emission
    logic               emitting, fire;
    logic [COL_W-1:0]   col_nx;
    logic               mid_ok, end_ok;
    logic signed [ACC_W-1:0] sh_acc;
    logic [GAP_W-1:0]   sh_gap;
    logic [COL_W-1:0]   sh_col;
    logic               sh_last;
    t_res               sh_res;

    always_comb begin
        emitting = (r_state == S_EMIT_A) || (r_state == S_EMIT_M) ||
                   (r_state == S_EMIT_B);
        fire     = emitting && (!r_ovalid || i_m_axis_tready);
        col_nx   = r_col + 1'b1;
        mid_ok   = (col_nx < r_c2) && (col_nx < COL_TILE);
        end_ok   = (r_c2 < COL_TILE);
        sh_acc   = (r_state == S_EMIT_B) ? r_acc_end : r_acc;
        sh_col   = (r_state == S_EMIT_B) ? r_c2 : r_col;
        sh_gap   = (r_state == S_EMIT_A) ? r_gap1 :
                   (r_state == S_EMIT_B) ? r_gap2 : GAP_ONE;
        sh_last  = (r_state == S_EMIT_B) || (!end_ok && (r_col == COL_EDGE));
    end

    alr_shade u_shade (
        .i_acc   (sh_acc),
        .i_gap   (sh_gap),
        .i_col   (sh_col),
        .i_steep (r_steep),
        .i_last  (sh_last),
        .o_res   (sh_res)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_s_axis_tvalid) n_state = S_SETUP;
            S_SETUP:  n_state = S_DSTART;
            S_DSTART: n_state = S_DIV;
            S_DIV:    if (div_done) n_state = S_MULS;
            S_MULS:   n_state = S_MULE;
            S_MULE:   n_state = (r_c1 < COL_TILE) ? S_EMIT_A : S_IDLE;
            S_EMIT_A, S_EMIT_M: begin
                if (fire) begin
                    priority if (mid_ok) n_state = S_EMIT_M;
                    else if (end_ok)     n_state = S_EMIT_B;
                    else                 n_state = S_IDLE;
                end
            end
            S_EMIT_B: if (fire) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fire)
                r_ovalid <= 1'b1;
            else if (i_m_axis_tready)
                r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_sx <= i_s_axis_tdata[COORD_W-1:0];
            r_sy <= i_s_axis_tdata[2*COORD_W-1:COORD_W];
            r_ex <= i_s_axis_tdata[3*COORD_W-1:2*COORD_W];
            r_ey <= i_s_axis_tdata[4*COORD_W-1:3*COORD_W];
        end
        if (r_state == S_SETUP) begin
            r_steep <= steep;
            r_amin  <= amin;
            r_bmin  <= bmin;
            r_dmaj  <= bmaj - amaj;
            r_neg   <= dmin[COORD_W];
            r_mag   <= dmin[COORD_W] ? COORD_W'(-dmin) : dmin[COORD_W-1:0];
            r_c1    <= sum1[COORD_W:FRAC_BITS];
            r_c2    <= sum2[COORD_W:FRAC_BITS];
            r_gap1  <= GAP_ONE - GAP_W'(sum1[FRAC_BITS-1:0]);
            r_gap2  <= GAP_W'(sum2[FRAC_BITS-1:0]);
            r_off1  <= $signed(GAP_W'(FRAC_HALF)) - $signed(GAP_W'(sum1[FRAC_BITS-1:0]));
            r_off2  <= $signed(GAP_W'(FRAC_HALF)) - $signed(GAP_W'(sum2[FRAC_BITS-1:0]));
        end
        if ((r_state == S_DIV) && div_done) begin
            if (r_dmaj == '0)
                r_grad <= '0;
            else if (r_neg)
                r_grad <= -$signed({1'b0, div_quo});
            else
                r_grad <= $signed({1'b0, div_quo});
        end
        if (r_state == S_MULS)
            r_acc <= mul_acc;
        if (r_state == S_MULE) begin
            r_acc_end <= mul_acc;
            r_col     <= r_c1;
        end
        if (fire && (r_state != S_EMIT_B)) begin
            r_acc <= r_acc + grad_step;
            r_col <= col_nx;
        end
        if (fire)
            r_res <= sh_res;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = OUT_TDATA_W'({r_res.far_i, r_res.near_i, r_res.minor,
                                          r_res.major});
    assign o_m_axis_tuser  = r_res.steep;
    assign o_m_axis_tlast  = r_res.last;

endmodule

### bench/antialiased_line_rasterizer_tb.sv
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer_tb: self-checking bench for the Wu line block
// Sends line segments on the input stream and predicts every column word
// (pixel pair, coverages, steep flag, last flag) in fixed point. Each output
// word is checked against the oldest prediction. Both stream sides idle at
// random, with some stretches at full rate.
// ----------------------------------------------------------------------------
module antialiased_line_rasterizer_tb;

    import alr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 200;

    typedef logic [COORD_W-1:0] t_coord;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_valid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_data;
    logic                   o_m_axis_tvalid;
    logic                   m_ready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tuser;
    logic                   o_m_axis_tlast;

    t_res expected_columns[$];
    int   errors = 0;
    int   cycles = 0;
    bit   no_idle;

    antialiased_line_rasterizer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ---- predictor ----
    function automatic t_res make_column(longint col, longint acc, longint gap, bit steep);
        t_res   w;
        longint p;
        longint f;
        longint nearv;
        longint farv;
        longint imax;
        int     sh;
        imax  = (longint'(1) << INTENSITY_BITS) - 1;
        sh    = ACC_FRAC + FRAC_BITS;
        p     = acc >>> ACC_FRAC;
        f     = acc - (p << ACC_FRAC);
        nearv = (((longint'(1) << ACC_FRAC) - f) * gap * imax + (longint'(1) << (sh - 1))) >>> sh;
        farv  = (f * gap * imax + (longint'(1) << (sh - 1))) >>> sh;
        if (p < 0) begin
            w.minor = '0;
            nearv   = farv;
            farv    = 0;
        end else if (p >= TILE_SIZE) begin
            w.minor = TILE_W'(TILE_SIZE - 1);
            nearv   = 0;
            farv    = 0;
        end else begin
            w.minor = TILE_W'(p);
            if (p == TILE_SIZE - 1)
                farv = 0;
        end
        w.major  = TILE_W'(col);
        w.near_i = INTENSITY_BITS'(nearv);
        w.far_i  = INTENSITY_BITS'(farv);
        w.steep  = steep;
        w.last   = 1'b0;
        return w;
    endfunction

    function automatic void predict_segment(t_coord sx, t_coord sy, t_coord ex, t_coord ey);
        longint one;
        longint half;
        longint dx, dy, a_maj, a_min, b_maj, b_min, t;
        longint dmaj, dmin, mag, grad, c1, c2, c;
        bit     steep;
        t_res   batch[$];
        one   = longint'(1) << FRAC_BITS;
        half  = longint'(1) << (FRAC_BITS - 1);
        dx    = longint'(ex) - longint'(sx);
        dy    = longint'(ey) - longint'(sy);
        steep = !((dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy));
        if (steep) begin
            a_maj = sy; a_min = sx; b_maj = ey; b_min = ex;
        end else begin
            a_maj = sx; a_min = sy; b_maj = ex; b_min = ey;
        end
        if (a_maj > b_maj) begin
            t = a_maj; a_maj = b_maj; b_maj = t;
            t = a_min; a_min = b_min; b_min = t;
        end
        dmaj = b_maj - a_maj;
        dmin = b_min - a_min;
        grad = 0;
        if (dmaj != 0) begin
            mag  = dmin < 0 ? -dmin : dmin;
            grad = ((mag << GRAD_FRAC) + dmaj / 2) / dmaj;
            if (dmin < 0)
                grad = -grad;
        end
        c1 = (a_maj + half) >> FRAC_BITS;
        c2 = (b_maj + half) >> FRAC_BITS;
        if (c1 < TILE_SIZE)
            batch.push_back(make_column(c1, (a_min << GRAD_FRAC) + grad * (c1 * one - a_maj),
                                        one - ((a_maj + half) & (one - 1)), steep));
        for (c = c1 + 1; c < c2 && c < TILE_SIZE; c++)
            batch.push_back(make_column(c, (a_min << GRAD_FRAC) + grad * (c * one - a_maj),
                                        one, steep));
        if (c2 < TILE_SIZE)
            batch.push_back(make_column(c2, (b_min << GRAD_FRAC) + grad * (c2 * one - b_maj),
                                        (b_maj + half) & (one - 1), steep));
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            expected_columns.push_back(batch[i]);
    endfunction

    // ---- output side ----
    initial begin
        int stall;
        m_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_axis_tvalid && m_ready && i_rst_n));
        end
    end

    task automatic check_field(string name, int expv, int actv);
        if (expv !== actv) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_res w;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            if (expected_columns.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual tdata %h", $time,
                         o_m_axis_tdata);
                errors++;
            end else begin
                w = expected_columns.pop_front();
                check_field("major_coord", w.major, o_m_axis_tdata[TILE_W-1:0]);
                check_field("minor_coord", w.minor, o_m_axis_tdata[2*TILE_W-1:TILE_W]);
                check_field("near_intensity", w.near_i,
                            o_m_axis_tdata[2*TILE_W+INTENSITY_BITS-1:2*TILE_W]);
                check_field("far_intensity", w.far_i,
                            o_m_axis_tdata[2*TILE_W+2*INTENSITY_BITS-1:2*TILE_W+INTENSITY_BITS]);
                check_field("steep", w.steep, o_m_axis_tuser);
                check_field("last_column", w.last, o_m_axis_tlast);
            end
        end
    end

    // ---- input side ----
    task automatic send_segment(t_coord sx, t_coord sy, t_coord ex, t_coord ey);
        int gap;
        @(negedge i_clk);
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_data  <= IN_TDATA_W'({ey, ex, sy, sx});
        s_valid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_segment(sx, sy, ex, ey);
    endtask

    function automatic t_coord clip_coord(int v);
        if (v < 0)
            return '0;
        if (v > (1 << COORD_W) - 1)
            return '1;
        return t_coord'(v);
    endfunction

    task automatic test_extremes();
        send_segment(0, 0, 0, 0);
        send_segment(1023, 1023, 1023, 1023);
        send_segment(0, 0, 1023, 0);
        send_segment(0, 0, 0, 1023);
        send_segment(1023, 1023, 0, 0);
        send_segment(0, 1023, 1023, 0);
        send_segment(1023, 0, 0, 1023);
        send_segment(1023, 1023, 0, 1023);
    endtask

    task automatic test_special_cases();
        send_segment(333, 517, 333, 517);       // zero length inside tile
        send_segment(97, 200, 103, 201);        // both ends in one column
        send_segment(200, 97, 201, 103);        // same, steep
        send_segment(0, 300, 1016, 310);        // end column rounds off tile
        send_segment(1016, 10, 1020, 12);       // every column off tile
        send_segment(0, 5, 1015, 5);            // end column at tile edge
        send_segment(4, 0, 100, 40);            // minor below tile
        send_segment(0, 4, 40, 100);            // minor below tile, steep
        send_segment(20, 1023, 200, 900);       // minor above tile
        send_segment(0, 1010, 500, 1010);       // far pixel off tile
    endtask

    task automatic test_random_segments(int count);
        int     kind;
        t_coord sx, sy, ex, ey;
        repeat (count) begin
            kind = $urandom_range(0, 9);
            sx   = t_coord'($urandom_range(0, 1023));
            sy   = t_coord'($urandom_range(0, 1023));
            ex   = t_coord'($urandom_range(0, 1023));
            ey   = t_coord'($urandom_range(0, 1023));
            if (kind >= 6 && kind <= 7) begin
                ex = clip_coord(int'(sx) + $urandom_range(0, 96) - 48);
                ey = clip_coord(int'(sy) + $urandom_range(0, 96) - 48);
            end else if (kind == 8) begin
                if ($urandom_range(0, 1))
                    ey = sy;
                else
                    ex = sx;
            end else if (kind == 9) begin
                sx = clip_coord($urandom_range(0, 1) ? $urandom_range(0, 24)
                                                     : $urandom_range(990, 1023));
                sy = clip_coord($urandom_range(0, 1) ? $urandom_range(0, 24)
                                                     : $urandom_range(990, 1023));
            end
            send_segment(sx, sy, ex, ey);
        end
    endtask

    task automatic test_back_to_back(int count);
        no_idle = 1'b1;
        test_random_segments(count);
        no_idle = 1'b0;
    endtask

    initial begin
        no_idle = 1'b0;
        i_rst_n = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_extremes();
        test_special_cases();
        test_random_segments(70);
        test_back_to_back(30);
        test_random_segments(40);

        @(negedge i_clk);
        s_valid <= 1'b0;
        while (expected_columns.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
